// File: rtl/core/lks_pkg.sv
`default_nettype none
package lks_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W     = 31;
    localparam int CAP_W     = 5;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    // Default number of entries in the set.
    localparam int DEF_MAX_ENTRIES = 16;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in s_tuser.
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the accepted word
        logic look;    // run the parallel compares
        logic update;  // apply the operation and load the result register
    } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/lks_ctrl.sv
`default_nettype none
module lks_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output lks_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        cmd.load   = s_tvalid && (state_reg == ST_IDLE);
        cmd.look   = (state_reg == ST_LOOK);
        cmd.update = (state_reg == ST_UPDATE) && (!out_valid_reg || m_tready);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // Hold here while the previous result is still waiting.
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/lks_dpath.sv
`default_nettype none
module lks_dpath #(
    parameter int MAX_ENTRIES = lks_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lks_pkg::cmd_t                 cmd,
    input  wire logic                          cfg_wen,
    input  wire logic [lks_pkg::CAP_W-1:0]     cfg_wdata,
    input  wire logic                          in_op,
    input  wire logic [lks_pkg::KEY_W-1:0]     in_key,
    output logic                               out_found,
    output logic [lks_pkg::KEY_W-1:0]          out_found_key,
    output logic                               out_evicted,
    output logic [lks_pkg::KEY_W-1:0]          out_evicted_key
);

    localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > lks_pkg::CAP_W) ? OCC_W : lks_pkg::CAP_W;

    // Entry storage.
    logic [lks_pkg::KEY_W-1:0] key_reg [MAX_ENTRIES];
    logic [AGE_W-1:0]          age_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]    valid_reg;
    logic [OCC_W-1:0]          occ_reg;
    logic [lks_pkg::CAP_W-1:0] cap_reg;

    // Captured request and lookup results.
    logic                      op_reg;
    logic [lks_pkg::KEY_W-1:0] req_key_reg;
    logic [MAX_ENTRIES-1:0]    hit_vec_reg;
    logic [MAX_ENTRIES-1:0]    victim_vec_reg;
    logic [MAX_ENTRIES-1:0]    free_vec_reg;
    logic                      full_reg;

    // Result register.
    logic                      found_reg;
    logic [lks_pkg::KEY_W-1:0] found_key_reg;
    logic                      evicted_reg;
    logic [lks_pkg::KEY_W-1:0] evicted_key_reg;

    logic [CMP_W-1:0]          cap_eff;
    logic [CMP_W-1:0]          cap_ext;
    logic [OCC_W-1:0]          occ_m1_full;
    logic [AGE_W-1:0]          occ_m1;
    logic [MAX_ENTRIES-1:0]    hit_vec;
    logic [MAX_ENTRIES-1:0]    victim_vec;
    logic [MAX_ENTRIES-1:0]    free_vec;
    logic [MAX_ENTRIES-1:0]    free_first;

    // The least recent valid entry is the one whose rank equals occupancy minus one.
    assign occ_m1_full = occ_reg - OCC_W'(1);
    assign occ_m1      = occ_m1_full[AGE_W-1:0];

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            cap_eff = CMP_W'(MAX_ENTRIES);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_vec[i]    = valid_reg[i] && (key_reg[i] == req_key_reg);
            victim_vec[i] = valid_reg[i] && (age_reg[i] == occ_m1);
        end
    end

    // Lowest free entry as a one-hot vector.
    assign free_vec   = ~valid_reg;
    assign free_first = free_vec & (~free_vec + MAX_ENTRIES'(1));

    // Update-phase decode.
    logic                      hit_any;
    logic [AGE_W-1:0]          hit_age;
    logic [lks_pkg::KEY_W-1:0] victim_key;
    logic                      is_put;
    logic                      do_evict;
    logic                      do_insert;
    logic [MAX_ENTRIES-1:0]    target_vec;
    logic [AGE_W-1:0]          age_limit;

    always_comb begin
        hit_age    = '0;
        victim_key = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_vec_reg[i]) begin
                hit_age = hit_age | age_reg[i];
            end
            if (victim_vec_reg[i]) begin
                victim_key = victim_key | key_reg[i];
            end
        end
    end

    always_comb begin
        hit_any   = |hit_vec_reg;
        is_put    = (op_reg == lks_pkg::OP_PUT);
        do_evict  = is_put && !hit_any && full_reg;
        do_insert = is_put && !hit_any && !full_reg;
        if (hit_any) begin
            target_vec = hit_vec_reg;
            age_limit  = hit_age;
        end else if (full_reg) begin
            target_vec = victim_vec_reg;
            age_limit  = occ_m1;
        end else begin
            target_vec = free_vec_reg;
            age_limit  = occ_m1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lks_pkg::CAP_RESET;
        end else if (cfg_wen) begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_op;
            req_key_reg <= in_key;
        end
        if (cmd.look) begin
            hit_vec_reg    <= hit_vec;
            victim_vec_reg <= victim_vec;
            free_vec_reg   <= free_first;
            full_reg       <= (CMP_W'(occ_reg) >= cap_eff);
        end
        if (cmd.update) begin
            found_reg       <= hit_any;
            found_key_reg   <= hit_any ? req_key_reg : '0;
            evicted_reg     <= do_evict;
            evicted_key_reg <= do_evict ? victim_key : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && is_put) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (target_vec[i]) begin
                    key_reg[i] <= req_key_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else if (cmd.update && is_put) begin
            // An insert ages every valid entry; otherwise only entries
            // more recent than the one being moved to the front.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (target_vec[i]) begin
                    age_reg[i] <= '0;
                end else if (valid_reg[i] && (do_insert || age_reg[i] < age_limit)) begin
                    age_reg[i] <= age_reg[i] + AGE_W'(1);
                end
            end
            if (do_insert) begin
                valid_reg <= valid_reg | target_vec;
                occ_reg   <= occ_reg + OCC_W'(1);
            end
        end
    end

    assign out_found       = found_reg;
    assign out_found_key   = found_key_reg;
    assign out_evicted     = evicted_reg;
    assign out_evicted_key = evicted_key_reg;

endmodule
`default_nettype wire

// File: rtl/core/lru_key_set.sv
// lru_key_set: fully associative key set with least-recently-used replacement.
//
// Input channel (s_*): one word per request. s_tuser[0] is the operation
// (0 put, 1 get) and s_tdata[30:0] the key. A put makes the key the most
// recent entry, evicting the least recent one when the set is at capacity.
// A get only reports presence and leaves recency untouched.
// Result channel (m_*): exactly one word per request, in request order,
// carrying found/evicted flags in m_tuser and the two keys in m_tdata.
// Configuration: cfg_wen with cfg_wdata sets the capacity; write it only while
// the block is idle. Zero acts as one, values above MAX_ENTRIES saturate.
//
// Timing: a request is accepted in the idle state, the key and age compares
// over all entries are registered in the next cycle, and the update and result
// register are loaded in the update step. The result becomes valid with that
// load, and a new request is taken only after this three-step controller
// sequence has returned to idle. If the receiver stalls, the block finishes
// the current lookup and holds in its update step until the pending result
// is taken. Reset empties the set and restores capacity 16.
`default_nettype none
module lru_key_set #(
    parameter int MAX_ENTRIES = lks_pkg::DEF_MAX_ENTRIES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Fields from bit 0: key[30:0], zero pad[31].
    input  wire logic [lks_pkg::S_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0: op[0].
    input  wire logic [lks_pkg::S_TUSER_W-1:0]     s_tuser,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: found_key[30:0], evicted_key[61:31], zero pad[63:62].
    output logic [lks_pkg::M_TDATA_W-1:0]          m_tdata,
    // Fields from bit 0: found[0], evicted[1].
    output logic [lks_pkg::M_TUSER_W-1:0]          m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_wen,
    input  wire logic [lks_pkg::CAP_W-1:0]         cfg_wdata
);

    lks_pkg::cmd_t             cmd;
    logic                      found;
    logic                      evicted;
    logic [lks_pkg::KEY_W-1:0] found_key;
    logic [lks_pkg::KEY_W-1:0] evicted_key;

    lks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lks_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .in_op           (s_tuser[0]),
        .in_key          (s_tdata[lks_pkg::KEY_W-1:0]),
        .out_found       (found),
        .out_found_key   (found_key),
        .out_evicted     (evicted),
        .out_evicted_key (evicted_key)
    );

    // The pad bits of s_tdata carry nothing.
    assign m_tdata = {2'b00, evicted_key, found_key};
    assign m_tuser = {evicted, found};

endmodule
`default_nettype wire

// File: rtl/core/lks_checker.sv
`default_nettype none
module lks_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [lks_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [lks_pkg::M_TUSER_W-1:0] m_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One request at a time: no acceptance right after an acceptance.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // The found key is zero unless the key was present.
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[30:0] == 31'd0)
        else $error("found key not zero on a miss");

    // The evicted key is zero unless an eviction happened.
    a_evict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[61:31] == 31'd0)
        else $error("evicted key not zero without eviction");

endmodule

bind lru_key_set lks_checker u_lks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire
